>>> hdl/cbh_pkg.sv
// shared types and constants of the clamped bucket histogram
package cbh_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_SPARE  = 2'd3
	} cbh_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_UPD  = 2'b10
	} cbh_state_t;

	localparam int unsigned BOUND_WIDTH = 7;
	localparam logic [BOUND_WIDTH-1:0] BOUNDARY_RESET = 7'd10;
	localparam int unsigned VALUE_WIDTH = 32;
	localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;

endpackage

>>> hdl/cbh_in_if.sv
// request channel of the histogram: command and sample item
interface cbh_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic signed [31:0] sample;
	logic              sample_is_inf;
	logic              sample_is_nan;
	logic [7:0]        bin_index;

	modport source (
		output valid, command, sample, sample_is_inf, sample_is_nan, bin_index,
		input  ready
	);
	modport sink (
		input  valid, command, sample, sample_is_inf, sample_is_nan, bin_index,
		output ready
	);
endinterface

>>> hdl/cbh_out_if.sv
// result channel of the histogram: bin count, totals and extremes
interface cbh_out_if;
	logic               valid;
	logic               ready;
	logic [31:0]        bin_count;
	logic [31:0]        finite_total;
	logic [31:0]        inf_total;
	logic [31:0]        nan_total;
	logic signed [31:0] min_value;
	logic signed [31:0] max_value;
	logic               any_finite;

	modport source (
		output valid, bin_count, finite_total, inf_total, nan_total,
		       min_value, max_value, any_finite,
		input  ready
	);
	modport sink (
		input  valid, bin_count, finite_total, inf_total, nan_total,
		       min_value, max_value, any_finite,
		output ready
	);
endinterface

>>> hdl/clamped_bucket_histogram.sv
// top level of the clamped bucket histogram
// Each item (insert, read bin, clear) is accepted while idle, and the bin ram is
// read at the clamped sample bin and at the reported bin. In the update state, once
// the output register is free or being taken, the count is incremented and written
// back for a finite insert and the result item is loaded into the output register.
// A new item is accepted whenever the block is idle, also while a result still
// waits to be taken. Bins live in a ram of 2*MAX_BOUND+1 entries with one valid
// flop each, so reset and clear take effect at once with no clearing pass.
module clamped_bucket_histogram #(
	parameter int unsigned MAX_BOUND   = 127,
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	cbh_in_if.sink                          req,
	cbh_out_if.source                       rsp,
	input  logic                            boundary_we,
	input  logic [cbh_pkg::BOUND_WIDTH-1:0] boundary_wdata
);

	localparam int unsigned NUM_BINS = 2 * MAX_BOUND + 1;
	localparam int unsigned AW = $clog2(NUM_BINS);
	localparam int unsigned VD = 2 ** AW;
	localparam int unsigned BW = ($clog2(MAX_BOUND + 1) > cbh_pkg::BOUND_WIDTH) ?
		$clog2(MAX_BOUND + 1) : cbh_pkg::BOUND_WIDTH;
	localparam int unsigned XW = 34;
	localparam int unsigned VW = cbh_pkg::VALUE_WIDTH;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (c == '1) ? c : c + COUNT_WIDTH'(1);
	endfunction

	cbh_pkg::cbh_state_t st_q;
	logic [cbh_pkg::BOUND_WIDTH-1:0] boundary_q;

	logic [COUNT_WIDTH-1:0] fin_q, inf_q, nan_q;
	logic signed [VW-1:0]   min_q, max_q;
	logic [VD-1:0]          vld_q;

	logic                   ins_fin_s1, ins_inf_s1, ins_nan_s1, clr_s1, rng_s1;
	logic signed [VW-1:0]   sample_s1;
	logic [AW-1:0]          widx_s1, ridx_s1;

	logic                   rsp_vld_q;
	logic [VW-1:0]          bin_count_q, fin_out_q, inf_out_q, nan_out_q;
	logic signed [VW-1:0]   min_out_q, max_out_q;
	logic                   any_q;

	logic [BW-1:0]          bnd_eff;
	logic signed [XW-1:0]   fl, bs, fl_c, idx_x;
	logic [AW-1:0]          idx, ra, rb;
	logic                   in_rng, acc, upd_go;
	logic [1:0]             cmd;
	logic [COUNT_WIDTH-1:0] rd_a, rd_b, old_a, new_a, bin_n;
	logic [COUNT_WIDTH-1:0] fin_n, inf_n, nan_n;
	logic signed [VW-1:0]   min_n, max_n;

	// effective bound, floor and clamp
	always_comb begin
		bnd_eff = (BW'(boundary_q) > BW'(MAX_BOUND)) ? BW'(MAX_BOUND) : BW'(boundary_q);
		bs      = $signed({{(XW-BW){1'b0}}, bnd_eff});
		fl      = XW'($signed(req.sample) >>> FRAC_BITS);
		if (fl < -bs) begin
			fl_c = -bs;
		end else if (fl > bs) begin
			fl_c = bs;
		end else begin
			fl_c = fl;
		end
		idx_x  = fl_c + bs;
		idx    = idx_x[AW-1:0];
		in_rng = XW'(req.bin_index) <= XW'({bnd_eff, 1'b0});
	end

	assign req.ready = (st_q == cbh_pkg::S_IDLE);
	assign acc       = req.valid && req.ready;
	assign cmd       = req.command;
	assign upd_go    = (st_q == cbh_pkg::S_UPD) && (!rsp_vld_q || rsp.ready);

	assign ra = (st_q == cbh_pkg::S_IDLE) ? idx : widx_s1;
	assign rb = (st_q == cbh_pkg::S_IDLE) ? AW'(req.bin_index) : ridx_s1;

	cbh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NUM_BINS)
	) u_bins (
		.clk    (clk),
		.we     (upd_go && ins_fin_s1),
		.waddr  (widx_s1),
		.wdata  (new_a),
		.raddr_a(ra),
		.raddr_b(rb),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// update of counters and extremes
	always_comb begin
		old_a = vld_q[widx_s1] ? rd_a : '0;
		new_a = sat_inc(old_a);
		if (clr_s1) begin
			fin_n = '0;
			inf_n = '0;
			nan_n = '0;
			min_n = cbh_pkg::VALUE_MAX;
			max_n = cbh_pkg::VALUE_MIN;
		end else begin
			fin_n = ins_fin_s1 ? sat_inc(fin_q) : fin_q;
			inf_n = ins_inf_s1 ? sat_inc(inf_q) : inf_q;
			nan_n = ins_nan_s1 ? sat_inc(nan_q) : nan_q;
			min_n = (ins_fin_s1 && sample_s1 < min_q) ? sample_s1 : min_q;
			max_n = (ins_fin_s1 && sample_s1 > max_q) ? sample_s1 : max_q;
		end
		if (!rng_s1 || clr_s1) begin
			bin_n = '0;
		end else if (ins_fin_s1 && ridx_s1 == widx_s1) begin
			bin_n = new_a;
		end else if (vld_q[ridx_s1]) begin
			bin_n = rd_b;
		end else begin
			bin_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boundary_q <= cbh_pkg::BOUNDARY_RESET;
		end else if (boundary_we) begin
			boundary_q <= boundary_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cbh_pkg::S_IDLE;
		end else begin
			case (st_q)
				cbh_pkg::S_IDLE: begin
					if (acc) begin
						st_q <= cbh_pkg::S_UPD;
					end
				end
				cbh_pkg::S_UPD: begin
					if (upd_go) begin
						st_q <= cbh_pkg::S_IDLE;
					end
				end
				default: st_q <= cbh_pkg::S_IDLE;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (acc) begin
			ins_fin_s1 <= (cmd == cbh_pkg::CMD_INSERT) && !req.sample_is_inf
				&& !req.sample_is_nan;
			ins_inf_s1 <= (cmd == cbh_pkg::CMD_INSERT) && req.sample_is_inf;
			ins_nan_s1 <= (cmd == cbh_pkg::CMD_INSERT) && !req.sample_is_inf
				&& req.sample_is_nan;
			clr_s1     <= (cmd == cbh_pkg::CMD_CLEAR);
			rng_s1     <= in_rng;
			sample_s1  <= req.sample;
			widx_s1    <= idx;
			ridx_s1    <= AW'(req.bin_index);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= '0;
			inf_q <= '0;
			nan_q <= '0;
			min_q <= cbh_pkg::VALUE_MAX;
			max_q <= cbh_pkg::VALUE_MIN;
			vld_q <= '0;
		end else if (upd_go) begin
			fin_q <= fin_n;
			inf_q <= inf_n;
			nan_q <= nan_n;
			min_q <= min_n;
			max_q <= max_n;
			if (clr_s1) begin
				vld_q <= '0;
			end else if (ins_fin_s1) begin
				vld_q[widx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (upd_go) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			bin_count_q <= VW'(bin_n);
			fin_out_q   <= VW'(fin_n);
			inf_out_q   <= VW'(inf_n);
			nan_out_q   <= VW'(nan_n);
			min_out_q   <= min_n;
			max_out_q   <= max_n;
			any_q       <= (fin_n != '0);
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.bin_count    = bin_count_q;
	assign rsp.finite_total = fin_out_q;
	assign rsp.inf_total    = inf_out_q;
	assign rsp.nan_total    = nan_out_q;
	assign rsp.min_value    = min_out_q;
	assign rsp.max_value    = max_out_q;
	assign rsp.any_finite   = any_q;

	a_acc_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (st_q == cbh_pkg::S_UPD))
		else $error("accepted item did not enter update");

	a_rsp_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(st_q == cbh_pkg::S_UPD))
		else $error("result without update");

	a_clear_vld: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && clr_s1) |=> (vld_q == '0))
		else $error("clear left valid bins");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && ins_fin_s1 && !clr_s1) |=> (min_q <= max_q))
		else $error("minimum above maximum after finite insert");

endmodule

>>> hdl/cbh_ram.sv
// generic ram with one write port and two registered read ports
module cbh_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 255,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
